### rtl/tksd_pkg.sv
// ----------------------------------------------------------------------------
// Terminal key decoder package
// Shared key codes, byte constants, queue entry type and the plain byte
// classifier used by the front end.
// ----------------------------------------------------------------------------
package tksd_pkg;

    // Key kinds reported on the result channel.
    localparam logic [3:0] KEY_NONE   = 4'd0;
    localparam logic [3:0] KEY_CHAR   = 4'd1;
    localparam logic [3:0] KEY_ENTER  = 4'd2;
    localparam logic [3:0] KEY_BACKSP = 4'd3;
    localparam logic [3:0] KEY_TAB    = 4'd4;
    localparam logic [3:0] KEY_ESC    = 4'd5;
    localparam logic [3:0] KEY_UP     = 4'd6;
    localparam logic [3:0] KEY_DOWN   = 4'd7;
    localparam logic [3:0] KEY_RIGHT  = 4'd8;
    localparam logic [3:0] KEY_LEFT   = 4'd9;
    localparam logic [3:0] KEY_HOME   = 4'd10;
    localparam logic [3:0] KEY_END    = 4'd11;

    // Byte values that the decoder recognizes.
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_BS     = 8'h08;
    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_DEL    = 8'h7F;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] BYTE_TILDE  = 8'h7E;
    localparam logic [7:0] BYTE_LBRACK = 8'h5B;
    localparam logic [7:0] BYTE_CAP_O  = 8'h4F;
    localparam logic [7:0] BYTE_ZERO   = 8'h30;
    localparam logic [7:0] BYTE_NINE   = 8'h39;
    localparam logic [7:0] BYTE_A      = 8'h41;
    localparam logic [7:0] BYTE_B      = 8'h42;
    localparam logic [7:0] BYTE_C      = 8'h43;
    localparam logic [7:0] BYTE_D      = 8'h44;
    localparam logic [7:0] BYTE_F      = 8'h46;
    localparam logic [7:0] BYTE_H      = 8'h48;

    // One decoded byte group: an optional leading ESC and one key.
    typedef struct packed {
        logic       esc_first;
        logic [3:0] kind;
        logic [7:0] ch;
    } key_entry_t;

    // Result of classifying a byte from the idle phase.
    typedef struct packed {
        logic       emit;
        logic       to_esc;
        logic [3:0] kind;
        logic [7:0] ch;
    } idle_dec_t;

    // Classify a byte seen with no sequence pending.
    function automatic idle_dec_t idle_decode(input logic [7:0] b, input logic last);
        idle_dec_t d;
        d.emit   = 1'b1;
        d.to_esc = 1'b0;
        d.kind   = KEY_NONE;
        d.ch     = 8'd0;
        if (b == BYTE_CR || b == BYTE_LF) begin
            d.kind = KEY_ENTER;
        end else if (b == BYTE_DEL || b == BYTE_BS) begin
            d.kind = KEY_BACKSP;
        end else if (b == BYTE_TAB) begin
            d.kind = KEY_TAB;
        end else if (b == BYTE_ESC) begin
            d.kind = KEY_ESC;
            if (!last) begin
                d.emit   = 1'b0;
                d.to_esc = 1'b1;
            end
        end else if (b < BYTE_SPACE) begin
            d.kind = KEY_NONE;
        end else begin
            d.kind = KEY_CHAR;
            d.ch   = b;
        end
        return d;
    endfunction

endpackage

### rtl/tksd_front.sv
// ----------------------------------------------------------------------------
// Terminal key decoder front end
// Accepts input bytes, tracks the escape sequence parser and pushes one
// queue entry for every byte that yields at least one key.
// ----------------------------------------------------------------------------
module tksd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] byte_value
    input  logic                s_tlast,    // burst_end
    input  logic                q_full,
    output logic                q_push,
    output tksd_pkg::key_entry_t q_entry
);

    // Parser phase codes.
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_ESC     = 2'd1;
    localparam logic [1:0] PH_BRACKET = 2'd2;
    localparam logic [1:0] PH_NUMBER  = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] num_reg, num_next;
    logic       accept;
    logic       push;
    logic       digit;
    logic [7:0] digit_val;
    tksd_pkg::key_entry_t entry;
    tksd_pkg::idle_dec_t  dec;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign digit     = (s_tdata >= tksd_pkg::BYTE_ZERO) && (s_tdata <= tksd_pkg::BYTE_NINE);
    assign digit_val = s_tdata - tksd_pkg::BYTE_ZERO;
    assign dec       = tksd_pkg::idle_decode(s_tdata, s_tlast);

    // Parser next state and the entry produced by the current byte.
    always_comb begin
        phase_next      = phase_reg;
        num_next        = num_reg;
        push            = 1'b0;
        entry.esc_first = 1'b0;
        entry.kind      = tksd_pkg::KEY_ESC;
        entry.ch        = 8'd0;
        unique case (phase_reg)
            PH_IDLE: begin
                push       = dec.emit;
                entry.kind = dec.kind;
                entry.ch   = dec.ch;
                phase_next = dec.to_esc ? PH_ESC : PH_IDLE;
            end
            PH_ESC: begin
                if (s_tdata == tksd_pkg::BYTE_LBRACK || s_tdata == tksd_pkg::BYTE_CAP_O) begin
                    if (s_tlast) begin
                        push       = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_BRACKET;
                    end
                end else begin
                    // Breaking byte: report ESC, then decode the byte again.
                    push            = 1'b1;
                    entry.esc_first = dec.emit;
                    entry.kind      = dec.emit ? dec.kind : tksd_pkg::KEY_ESC;
                    entry.ch        = dec.ch;
                    phase_next      = dec.to_esc ? PH_ESC : PH_IDLE;
                end
            end
            PH_BRACKET: begin
                phase_next = PH_IDLE;
                push       = 1'b1;
                case (s_tdata)
                    tksd_pkg::BYTE_A: entry.kind = tksd_pkg::KEY_UP;
                    tksd_pkg::BYTE_B: entry.kind = tksd_pkg::KEY_DOWN;
                    tksd_pkg::BYTE_C: entry.kind = tksd_pkg::KEY_RIGHT;
                    tksd_pkg::BYTE_D: entry.kind = tksd_pkg::KEY_LEFT;
                    tksd_pkg::BYTE_H: entry.kind = tksd_pkg::KEY_HOME;
                    tksd_pkg::BYTE_F: entry.kind = tksd_pkg::KEY_END;
                    default: begin
                        if (digit && !s_tlast) begin
                            push       = 1'b0;
                            num_next   = digit_val;
                            phase_next = PH_NUMBER;
                        end
                    end
                endcase
            end
            PH_NUMBER: begin
                if (digit) begin
                    // Number times ten plus digit, kept modulo 256.
                    num_next = {num_reg[4:0], 3'b000} + {num_reg[6:0], 1'b0} + digit_val;
                    if (s_tlast) begin
                        push       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end else if (s_tdata == tksd_pkg::BYTE_TILDE) begin
                    push       = 1'b1;
                    phase_next = PH_IDLE;
                    if (num_reg == 8'd1 || num_reg == 8'd7) begin
                        entry.kind = tksd_pkg::KEY_HOME;
                    end else if (num_reg == 8'd4 || num_reg == 8'd8) begin
                        entry.kind = tksd_pkg::KEY_END;
                    end
                end else begin
                    push            = 1'b1;
                    entry.esc_first = dec.emit;
                    entry.kind      = dec.emit ? dec.kind : tksd_pkg::KEY_ESC;
                    entry.ch        = dec.ch;
                    phase_next      = dec.to_esc ? PH_ESC : PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Parser state advances only on an accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            num_reg   <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            num_reg   <= num_next;
        end
    end

    assign q_push  = accept && push;
    assign q_entry = entry;

endmodule

### rtl/tksd_queue.sv
// ----------------------------------------------------------------------------
// Terminal key decoder entry queue
// Small register queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module tksd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tksd_pkg::key_entry_t push_entry,
    input  logic                 pop,
    output tksd_pkg::key_entry_t head_entry,
    output logic                 empty,
    output logic                 full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tksd_pkg::key_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty      = (count_reg == '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_entry = mem_reg[rd_ptr_reg];

    // Pointer wrap and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy exceeds depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from an empty queue");
    a_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> !empty)
        else $error("queue empty after a push");
`endif

endmodule

### rtl/tksd_back.sv
// ----------------------------------------------------------------------------
// Terminal key decoder result sequencer
// Takes queue entries and sends their keys out through a registered
// result stage, one key per transaction.
// ----------------------------------------------------------------------------
module tksd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tksd_pkg::key_entry_t head_entry,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] key_char
    output logic [3:0]           m_tuser,   // [3:0] key_kind
    output logic                 m_tlast    // last_result
);

    logic       valid_reg, valid_next;
    logic       prefix_sent_reg, prefix_sent_next;
    logic [3:0] kind_reg, kind_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       load;

    // The output stage refills whenever it is empty or being taken.
    assign load = !valid_reg || m_tready;

    always_comb begin
        valid_next       = valid_reg;
        prefix_sent_next = prefix_sent_reg;
        kind_next        = kind_reg;
        char_next        = char_reg;
        last_next        = last_reg;
        q_pop            = 1'b0;
        if (load) begin
            valid_next = !q_empty;
            if (!q_empty) begin
                if (head_entry.esc_first && !prefix_sent_reg) begin
                    // Leading ESC of a broken sequence; the entry stays queued.
                    kind_next        = tksd_pkg::KEY_ESC;
                    char_next        = 8'd0;
                    last_next        = 1'b0;
                    prefix_sent_next = 1'b1;
                end else begin
                    kind_next        = head_entry.kind;
                    char_next        = head_entry.ch;
                    last_next        = 1'b1;
                    prefix_sent_next = 1'b0;
                    q_pop            = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            prefix_sent_reg <= 1'b0;
        end else begin
            valid_reg       <= valid_next;
            prefix_sent_reg <= prefix_sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

`ifndef ASSERT_OFF
    a_prefix_is_esc: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !last_reg) |-> (kind_reg == tksd_pkg::KEY_ESC && char_reg == 8'd0))
        else $error("non-final key is not a bare ESC");
    a_prefix_followed: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && m_tready && !last_reg) |=> (valid_reg && last_reg))
        else $error("leading ESC not followed by the final key");
    a_prefix_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        prefix_sent_reg |-> (valid_reg && !last_reg && !q_empty))
        else $error("prefix flag set without a pending leading ESC");
    a_char_only_for_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg != tksd_pkg::KEY_CHAR) |-> (char_reg == 8'd0))
        else $error("character field set on a non-character key");
`endif

endmodule

### rtl/terminal_key_sequence_decoder_top.sv
// ----------------------------------------------------------------------------
// Terminal key sequence decoder
// Decodes terminal input bytes, including ESC [ and ESC O sequences, into
// key events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one raw byte per transaction in s_tdata[7:0]; s_tlast
//   is set when no further byte of the burst is already available.
//   Result channel m_*: one key per transaction, kind in m_tuser[3:0] and the
//   printable byte in m_tdata[7:0]; m_tlast marks the final key that an
//   input byte caused. A byte gives zero, one or two keys.
//   A key passes from the parser through the entry queue into the registered
//   output stage before it appears on m_*.
//   Throughput: one byte per cycle on input while the queue is not full and
//   one key per cycle on output while m_tready is high; a byte that breaks a
//   sequence produces two keys, sent as two transactions. The parser and the
//   sequencer are parted by a QUEUE_DEPTH queue; input stalls only when it is full.
//   Reset: the parser returns to idle with a zero number, the queue and the
//   output stage are emptied.
//   Stall: while m_tready is low the current key holds on m_*; input keeps
//   being accepted until the queue fills, then s_tready falls.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_value
    input  logic        s_tlast,    // burst_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] key_char
    output logic [3:0]  m_tuser,    // [3:0] key_kind
    output logic        m_tlast     // last_result
);

    logic                 q_push;
    logic                 q_pop;
    logic                 q_empty;
    logic                 q_full;
    tksd_pkg::key_entry_t push_entry;
    tksd_pkg::key_entry_t head_entry;

    tksd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    tksd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .empty      (q_empty),
        .full       (q_full)
    );

    tksd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
